### hdl/flfc_pkg.sv
package flfc_pkg;

  // Field and register widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 7;
  localparam int unsigned DelimW = 3;
  localparam int unsigned SeqW   = 32;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CfgIdxW = 3;

  // Bytes held by one delimiter sequence register
  localparam int unsigned SeqBytes = SeqW / ByteW;

  // Default sizing
  localparam int unsigned MaxPacketDefault = 64;
  localparam int unsigned MaxDelimDefault  = 4;

  // Register reset values
  localparam logic [LenW-1:0]   PacketLengthRst = 7'd16;
  localparam logic [DelimW-1:0] HeaderLengthRst = 3'd2;
  localparam logic [DelimW-1:0] FooterLengthRst = 3'd2;
  localparam logic [SeqW-1:0]   HeaderBytesRst  = '0;
  localparam logic [SeqW-1:0]   FooterBytesRst  = '0;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPacketLength = 3'd0,
    CfgHeaderLength = 3'd1,
    CfgFooterLength = 3'd2,
    CfgHeaderBytes  = 3'd3,
    CfgFooterBytes  = 3'd4
  } cfg_idx_e;

  typedef enum logic [StatW-1:0] {
    StatNeedMore  = 2'd0,
    StatGood      = 2'd1,
    StatBadFooter = 2'd2,
    StatBadHeader = 2'd3
  } status_e;

endpackage

### hdl/flfc_if.sv
// Byte input channel
interface flfc_in_if;
  logic                          valid;
  logic                          ready;
  logic [flfc_pkg::ByteW-1:0]    data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// Check result channel
interface flfc_out_if;
  logic                          valid;
  logic                          ready;
  logic [flfc_pkg::StatW-1:0]    status;
  logic [flfc_pkg::LenW-1:0]     bytes_hint;

  modport source (output valid, output status, output bytes_hint, input ready);
  modport sink   (input valid, input status, input bytes_hint, output ready);
endinterface

### hdl/fixed_length_frame_checker.sv
// Channel   Dir  Payload                      Transfer when
// --------  ---  ---------------------------  ------------------------
// in_i      in   data_byte[7:0]               in_i.valid & in_i.ready
// out_o     out  status[1:0], bytes_hint[6:0] out_o.valid & out_o.ready
// cfg       in   cfg_index_i, cfg_data_i      cfg_we_i
//
// One byte per cycle sustained while results are taken; each byte's result
// is registered in the window stage, then in the result register.
// The window stage holds while the result register is full and not taken;
// input ready drops only then.
// Reset clears the byte count, stage valids, write pointer and config
// registers; the byte history is not cleared (never read before written).
module fixed_length_frame_checker #(
  parameter int unsigned MaxPacket = flfc_pkg::MaxPacketDefault,
  parameter int unsigned MaxDelim  = flfc_pkg::MaxDelimDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  flfc_in_if.sink                        in_i,
  flfc_out_if.source                     out_o,
  input  logic                           cfg_we_i,
  input  logic [flfc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [flfc_pkg::SeqW-1:0]      cfg_data_i
);

  localparam int unsigned IdxW   = $clog2(MaxPacket);
  localparam int unsigned Depth  = 2 ** IdxW;
  localparam int unsigned RecW   = $clog2(flfc_pkg::SeqBytes);
  // Delimiters are limited both by sizing and by the sequence register
  localparam int unsigned DelimN = (MaxDelim < flfc_pkg::SeqBytes) ?
                                   MaxDelim : flfc_pkg::SeqBytes;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [flfc_pkg::LenW-1:0]   plen_raw_q;
  logic [flfc_pkg::DelimW-1:0] hlen_raw_q;
  logic [flfc_pkg::DelimW-1:0] flen_raw_q;
  logic [flfc_pkg::SeqW-1:0]   hseq_q;
  logic [flfc_pkg::SeqW-1:0]   fseq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_raw_q <= flfc_pkg::PacketLengthRst;
      hlen_raw_q <= flfc_pkg::HeaderLengthRst;
      flen_raw_q <= flfc_pkg::FooterLengthRst;
      hseq_q     <= flfc_pkg::HeaderBytesRst;
      fseq_q     <= flfc_pkg::FooterBytesRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        flfc_pkg::CfgPacketLength: plen_raw_q <= cfg_data_i[flfc_pkg::LenW-1:0];
        flfc_pkg::CfgHeaderLength: hlen_raw_q <= cfg_data_i[flfc_pkg::DelimW-1:0];
        flfc_pkg::CfgFooterLength: flen_raw_q <= cfg_data_i[flfc_pkg::DelimW-1:0];
        flfc_pkg::CfgHeaderBytes:  hseq_q     <= cfg_data_i;
        flfc_pkg::CfgFooterBytes:  fseq_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective lengths: packet length forced into 1..MaxPacket, delimiters
  // limited to DelimN and to the packet length.
  logic [flfc_pkg::LenW-1:0] plen;
  logic [flfc_pkg::LenW-1:0] hlen;
  logic [flfc_pkg::LenW-1:0] flen;

  always_comb begin
    plen = plen_raw_q;
    if (plen == '0) begin
      plen = flfc_pkg::LenW'(1);
    end else if (int'(plen) > int'(MaxPacket)) begin
      plen = flfc_pkg::LenW'(MaxPacket);
    end

    hlen = flfc_pkg::LenW'(hlen_raw_q);
    if (int'(hlen) > int'(DelimN)) hlen = flfc_pkg::LenW'(DelimN);
    if (hlen > plen) hlen = plen;

    flen = flfc_pkg::LenW'(flen_raw_q);
    if (int'(flen) > int'(DelimN)) flen = flfc_pkg::LenW'(DelimN);
    if (flen > plen) flen = plen;
  end

  // ---------------------------------------------------------------------
  // Window stage. The last few bytes sit in a short shift line (newest at
  // 0), which covers the footer and short packets. Older bytes live in a
  // history memory: each transfer writes one word holding the new byte and
  // the three before it, and reads the word written plen-4 transfers ago,
  // which holds all header bytes of a packet that ends with the new byte.
  // ---------------------------------------------------------------------
  logic [flfc_pkg::ByteW-1:0] recent_q [flfc_pkg::SeqBytes];
  logic [flfc_pkg::SeqW-1:0]  hist_mem [Depth];
  logic [flfc_pkg::SeqW-1:0]  hist_word;
  logic [flfc_pkg::SeqW-1:0]  head_word_q;
  logic [IdxW-1:0]            wr_ptr_q;
  logic [IdxW-1:0]            rd_addr;
  logic                       win_vld_q;
  logic [flfc_pkg::LenW-1:0]  cnt1_q;   // count including the staged byte
  logic [flfc_pkg::LenW-1:0]  cnt_q;    // committed count, stage empty

  logic in_xfer;
  logic advance;
  logic good;

  assign advance  = win_vld_q && (!out_o.valid || out_o.ready);
  assign in_i.ready = !win_vld_q || advance;
  assign in_xfer  = in_i.valid && in_i.ready;

  // word layout: byte j back from the newest in bits 8j+7:8j
  always_comb begin
    hist_word = '0;
    hist_word[flfc_pkg::ByteW-1:0] = in_i.data_byte;
    for (int j = 1; j < int'(flfc_pkg::SeqBytes); j++) begin
      hist_word[j*flfc_pkg::ByteW +: flfc_pkg::ByteW] = recent_q[j-1];
    end
  end

  // only used when plen exceeds the shift line, so the word is older
  // than the one written in the same cycle
  assign rd_addr = wr_ptr_q -
                   IdxW'(plen - flfc_pkg::LenW'(flfc_pkg::SeqBytes));

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      hist_mem[wr_ptr_q] <= hist_word;
      head_word_q        <= hist_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      recent_q[0] <= in_i.data_byte;
      for (int j = 1; j < int'(flfc_pkg::SeqBytes); j++) begin
        recent_q[j] <= recent_q[j-1];
      end
    end
  end

  // Count for the incoming byte. A good packet in the stage being retired
  // this cycle clears the count before it is used.
  logic [flfc_pkg::LenW-1:0] cnt_base;
  logic [flfc_pkg::LenW-1:0] cnt1_d;

  always_comb begin
    if (win_vld_q) begin
      cnt_base = good ? '0 : cnt1_q;
    end else begin
      cnt_base = cnt_q;
    end
    if (cnt_base > plen) cnt_base = plen;
    cnt1_d = (cnt_base < plen) ? cnt_base + flfc_pkg::LenW'(1) : cnt_base;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_vld_q <= 1'b0;
      cnt1_q    <= '0;
      cnt_q     <= '0;
      wr_ptr_q  <= '0;
    end else begin
      if (in_xfer) begin
        win_vld_q <= 1'b1;
        cnt1_q    <= cnt1_d;
        wr_ptr_q  <= wr_ptr_q + IdxW'(1);
      end else if (advance) begin
        win_vld_q <= 1'b0;
      end
      if (advance) begin
        cnt_q <= good ? '0 : cnt1_q;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Checks on the staged window
  // ---------------------------------------------------------------------
  logic full;
  logic foot_ok;
  logic head_ok;

  always_comb begin
    full    = !(cnt1_q < plen);
    foot_ok = 1'b1;
    head_ok = 1'b1;
    for (int k = 0; k < int'(DelimN); k++) begin
      // footer byte k sits flen-1-k bytes before the newest
      if (k < int'(flen)) begin
        if (recent_q[RecW'(int'(flen) - k - 1)] !=
            fseq_q[k*flfc_pkg::ByteW +: flfc_pkg::ByteW]) begin
          foot_ok = 1'b0;
        end
      end
      // header byte k sits plen-1-k bytes before the newest
      if (k < int'(hlen)) begin
        if (plen <= flfc_pkg::LenW'(flfc_pkg::SeqBytes)) begin
          if (recent_q[RecW'(int'(plen) - k - 1)] !=
              hseq_q[k*flfc_pkg::ByteW +: flfc_pkg::ByteW]) begin
            head_ok = 1'b0;
          end
        end else if (head_word_q[(int'(flfc_pkg::SeqBytes) - 1 - k)*flfc_pkg::ByteW
                                 +: flfc_pkg::ByteW] !=
                     hseq_q[k*flfc_pkg::ByteW +: flfc_pkg::ByteW]) begin
          head_ok = 1'b0;
        end
      end
    end
  end

  assign good = full && foot_ok && head_ok;

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  flfc_pkg::status_e          status_d, status_q;
  logic [flfc_pkg::LenW-1:0]  hint_d, hint_q;
  logic                       out_vld_q;

  always_comb begin
    priority if (!full) begin
      status_d = flfc_pkg::StatNeedMore;
      hint_d   = plen - cnt1_q;
    end else if (!foot_ok) begin
      status_d = flfc_pkg::StatBadFooter;
      hint_d   = flen;
    end else if (!head_ok) begin
      status_d = flfc_pkg::StatBadHeader;
      hint_d   = plen;
    end else begin
      status_d = flfc_pkg::StatGood;
      hint_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q <= status_d;
      hint_q   <= hint_d;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.status     = status_q;
  assign out_o.bytes_hint = hint_q;

endmodule
